>>> design/snp_group_comparison_tally_defines.svh
// ----------------------------------------------------------------------------
// snp group comparison tally assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef SNP_GROUP_COMPARISON_TALLY_DEFINES_SVH
`define SNP_GROUP_COMPARISON_TALLY_DEFINES_SVH

// same-cycle implication
`define SGCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SGCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sgct_pkg.sv
// ----------------------------------------------------------------------------
// sgct_pkg
// types, codes and the iupac ambiguity table for the snp group comparison tally
// ----------------------------------------------------------------------------
package sgct_pkg;

	// default sizes
	localparam int NUM_ACCESSIONS_DEF = 8;
	localparam int COUNTER_BITS_DEF   = 32;

	// fixed field widths
	localparam int MAX_ACC    = 8;
	localparam int BASE_W     = 8;
	localparam int CODE_W     = 3;
	localparam int CODES_W    = CODE_W * MAX_ACC;
	localparam int FLAGS_W    = 6;
	localparam int GLOBAL_NUM = 6;
	localparam int GIDX_W     = 3;
	localparam int IDX_W      = 6;
	localparam int VALUE_W    = 32;
	localparam int CFG_W      = 4;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int KINDS      = 4;
	localparam int SET_W      = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// register index (paddr bit 2)
	localparam logic REG_ACC_IN_USE = 1'b0;

	// ascii space means no snp
	localparam logic [BASE_W-1:0] NO_SNP = 8'h20;

	// item opcodes
	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_READ     = 1'b1;

	// per-accession class codes
	localparam logic [CODE_W-1:0] CLS_NONE    = 3'd0;
	localparam logic [CODE_W-1:0] CLS_EXTRA   = 3'd1;
	localparam logic [CODE_W-1:0] CLS_ABSENT  = 3'd2;
	localparam logic [CODE_W-1:0] CLS_SHARED  = 3'd3;
	localparam logic [CODE_W-1:0] CLS_DIFFER  = 3'd4;

	// per-accession counter kinds
	localparam int KIND_EXTRA  = 0;
	localparam int KIND_SHARED = 1;
	localparam int KIND_ABSENT = 2;
	localparam int KIND_DIFFER = 3;

	// global counter / flag bit positions
	localparam int FLG_NOSRC_ALL  = 0;
	localparam int FLG_SHARED_ALL = 1;
	localparam int FLG_ABSENT_ALL = 2;
	localparam int FLG_SHARED_ANY = 3;
	localparam int FLG_EXTRA_ANY  = 4;
	localparam int FLG_SRC_SNP    = 5;

	// base set members: a c g t n
	localparam logic [SET_W-1:0] SET_A = 5'h01;
	localparam logic [SET_W-1:0] SET_C = 5'h02;
	localparam logic [SET_W-1:0] SET_G = 5'h04;
	localparam logic [SET_W-1:0] SET_T = 5'h08;
	localparam logic [SET_W-1:0] SET_N = 5'h10;

	typedef logic [BASE_W-1:0] base_t;
	typedef logic [SET_W-1:0]  base_set_t;

	typedef struct packed {
		logic [CODES_W-1:0] codes;
		logic [FLAGS_W-1:0] flags;
	} pos_result_t;

	// iupac expansion of a source code (N matches only a literal N), empty set for unknown codes
	function automatic base_set_t expand_code(base_t c);
		base_set_t s;
		case (c)
			8'h41:   s = SET_A;                 // A
			8'h43:   s = SET_C;                 // C
			8'h47:   s = SET_G;                 // G
			8'h54:   s = SET_T;                 // T
			8'h52:   s = SET_A | SET_G;         // R
			8'h59:   s = SET_C | SET_T;         // Y
			8'h4D:   s = SET_A | SET_C;         // M
			8'h4B:   s = SET_G | SET_T;         // K
			8'h53:   s = SET_C | SET_G;         // S
			8'h57:   s = SET_A | SET_T;         // W
			8'h48:   s = SET_A | SET_C | SET_T; // H
			8'h42:   s = SET_C | SET_G | SET_T; // B
			8'h44:   s = SET_A | SET_G | SET_T; // D
			8'h56:   s = SET_A | SET_C | SET_G; // V
			8'h4E:   s = SET_N;                 // N
			default: s = '0;
		endcase
		return s;
	endfunction

	// literal base as a single set member
	function automatic base_set_t char_bit(base_t c);
		base_set_t s;
		case (c)
			8'h41:   s = SET_A;
			8'h43:   s = SET_C;
			8'h47:   s = SET_G;
			8'h54:   s = SET_T;
			8'h4E:   s = SET_N;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

>>> design/snp_group_comparison_tally.sv
// a result passes through the input register and then the result register, which a stalled output holds
// throughput: one item per cycle while the result register is not held by a low out_ready
// a read item sees every counter update of the items accepted before it
// reset (arst_n low, asynchronous): all counters cleared, accessions_in_use = 8,
// input and output stages empty
// ----------------------------------------------------------------------------
// snp_group_comparison_tally
// per-position snp comparison of a source line against up to eight accessions
// with saturating global and per-accession tallies and counter readback
// ----------------------------------------------------------------------------
`include "snp_group_comparison_tally_defines.svh"

module snp_group_comparison_tally #(
	parameter int NUM_ACCESSIONS = sgct_pkg::NUM_ACCESSIONS_DEF,
	parameter int COUNTER_BITS   = sgct_pkg::COUNTER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sgct_pkg::PADDR_W-1:0]      paddr,
	input  logic [sgct_pkg::PDATA_W-1:0]      pwdata,
	output logic [sgct_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [sgct_pkg::IDX_W-1:0]        counter_index,
	input  logic [sgct_pkg::BASE_W-1:0]       source_base,
	input  logic [sgct_pkg::BASE_W-1:0]       acc_base_0,
	input  logic [sgct_pkg::BASE_W-1:0]       acc_base_1,
	input  logic [sgct_pkg::BASE_W-1:0]       acc_base_2,
	input  logic [sgct_pkg::BASE_W-1:0]       acc_base_3,
	input  logic [sgct_pkg::BASE_W-1:0]       acc_base_4,
	input  logic [sgct_pkg::BASE_W-1:0]       acc_base_5,
	input  logic [sgct_pkg::BASE_W-1:0]       acc_base_6,
	input  logic [sgct_pkg::BASE_W-1:0]       acc_base_7,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sgct_pkg::CODES_W-1:0]      class_codes,
	output logic [sgct_pkg::FLAGS_W-1:0]      position_flags,
	output logic [sgct_pkg::VALUE_W-1:0]      counter_value
);

	localparam int ACC_NUM   = sgct_pkg::KINDS * NUM_ACCESSIONS;
	localparam int ACC_IDX_W = $clog2(ACC_NUM);

	logic [sgct_pkg::CFG_W-1:0]                               acc_in_use_q;
	logic                                                     cfg_wr;

	logic [sgct_pkg::MAX_ACC-1:0][sgct_pkg::BASE_W-1:0]       acc_in;
	logic                                                     in_accept;
	logic                                                     out_load;

	logic                                                     valid_s1;
	logic                                                     opcode_s1;
	logic [sgct_pkg::IDX_W-1:0]                               index_s1;
	sgct_pkg::base_t                                          src_s1;
	logic [NUM_ACCESSIONS-1:0][sgct_pkg::BASE_W-1:0]          acc_s1;

	sgct_pkg::pos_result_t                                    cls_res;
	logic [ACC_NUM-1:0]                                       acc_inc;
	logic                                                     update_en;

	logic [COUNTER_BITS-1:0]                                  glob_cnt_q [sgct_pkg::GLOBAL_NUM];
	logic [COUNTER_BITS-1:0]                                  acc_cnt_q  [ACC_NUM];

	logic [sgct_pkg::IDX_W-1:0]                               acc_idx;
	logic [COUNTER_BITS-1:0]                                  rd_cnt;

	logic                                                     out_valid_q;
	logic [sgct_pkg::CODES_W-1:0]                             class_codes_q;
	logic [sgct_pkg::FLAGS_W-1:0]                             position_flags_q;
	logic [sgct_pkg::VALUE_W-1:0]                             counter_value_q;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == sgct_pkg::REG_ACC_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_in_use_q <= sgct_pkg::CFG_RESET;
		end else if (cfg_wr) begin
			acc_in_use_q <= pwdata[sgct_pkg::CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == sgct_pkg::REG_ACC_IN_USE)
		? sgct_pkg::PDATA_W'(acc_in_use_q) : '0;

	// handshake: stage 1 advances whenever the result register is free
	assign out_load  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || out_load;
	assign in_accept = in_valid && in_ready;

	assign acc_in = {acc_base_7, acc_base_6, acc_base_5, acc_base_4,
		acc_base_3, acc_base_2, acc_base_1, acc_base_0};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1 <= opcode;
			index_s1  <= counter_index;
			src_s1    <= source_base;
			acc_s1    <= acc_in[NUM_ACCESSIONS-1:0];
		end
	end

	// position classification
	sgct_classify #(
		.NUM_ACCESSIONS (NUM_ACCESSIONS)
	) u_classify (
		.acc_in_use (acc_in_use_q),
		.src_base   (src_s1),
		.acc_base   (acc_s1),
		.res        (cls_res),
		.acc_inc    (acc_inc)
	);

	assign update_en = out_load && (opcode_s1 == sgct_pkg::OP_CLASSIFY);

	// saturating global counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < sgct_pkg::GLOBAL_NUM; g++) begin
				glob_cnt_q[g] <= '0;
			end
		end else if (update_en) begin
			for (int g = 0; g < sgct_pkg::GLOBAL_NUM; g++) begin
				if (cls_res.flags[g] && (glob_cnt_q[g] != '1)) begin
					glob_cnt_q[g] <= glob_cnt_q[g] + COUNTER_BITS'(1);
				end
			end
		end
	end

	// saturating per-accession counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ACC_NUM; k++) begin
				acc_cnt_q[k] <= '0;
			end
		end else if (update_en) begin
			for (int k = 0; k < ACC_NUM; k++) begin
				if (acc_inc[k] && (acc_cnt_q[k] != '1)) begin
					acc_cnt_q[k] <= acc_cnt_q[k] + COUNTER_BITS'(1);
				end
			end
		end
	end

	// counter readback select, out-of-range reads return zero
	assign acc_idx = index_s1 - sgct_pkg::IDX_W'(sgct_pkg::GLOBAL_NUM);

	always_comb begin
		rd_cnt = '0;
		if (index_s1 < sgct_pkg::IDX_W'(sgct_pkg::GLOBAL_NUM)) begin
			rd_cnt = glob_cnt_q[index_s1[sgct_pkg::GIDX_W-1:0]];
		end else if (acc_idx < sgct_pkg::IDX_W'(ACC_NUM)) begin
			rd_cnt = acc_cnt_q[acc_idx[ACC_IDX_W-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (opcode_s1 == sgct_pkg::OP_READ) begin
				class_codes_q    <= '0;
				position_flags_q <= '0;
				counter_value_q  <= sgct_pkg::VALUE_W'(rd_cnt);
			end else begin
				class_codes_q    <= cls_res.codes;
				position_flags_q <= cls_res.flags;
				counter_value_q  <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign class_codes    = class_codes_q;
	assign position_flags = position_flags_q;
	assign counter_value  = counter_value_q;

	// checks
	`SGCT_ASSERT_IMPL(a_read_result_clean, clk, arst_n, out_valid_q && (counter_value_q != '0), (class_codes_q == '0) && (position_flags_q == '0), "read result carries class data")
	`SGCT_ASSERT_IMPL(a_flags_exclusive, clk, arst_n, out_valid_q && position_flags_q[sgct_pkg::FLG_SRC_SNP], !position_flags_q[sgct_pkg::FLG_NOSRC_ALL] && !position_flags_q[sgct_pkg::FLG_EXTRA_ANY], "source snp flags clash")
	`SGCT_ASSERT_NEXT(a_count_monotonic, clk, arst_n, 1'b1, glob_cnt_q[sgct_pkg::FLG_SRC_SNP] >= $past(glob_cnt_q[sgct_pkg::FLG_SRC_SNP]), "global counter decreased")
	`SGCT_ASSERT_NEXT(a_read_no_update, clk, arst_n, out_load && (opcode_s1 == sgct_pkg::OP_READ), $stable(glob_cnt_q[sgct_pkg::FLG_SRC_SNP]), "read item changed a counter")

endmodule

>>> design/sgct_classify.sv
// ----------------------------------------------------------------------------
// sgct_classify
// classifies each active accession against the source base and derives the
// global flags and per-accession counter increments for one position
// ----------------------------------------------------------------------------
module sgct_classify #(
	parameter int NUM_ACCESSIONS = sgct_pkg::NUM_ACCESSIONS_DEF
) (
	input  logic [sgct_pkg::CFG_W-1:0]                         acc_in_use,
	input  sgct_pkg::base_t                                    src_base,
	input  logic [NUM_ACCESSIONS-1:0][sgct_pkg::BASE_W-1:0]    acc_base,
	output sgct_pkg::pos_result_t                              res,
	output logic [sgct_pkg::KINDS*NUM_ACCESSIONS-1:0]          acc_inc
);

	logic [sgct_pkg::CFG_W-1:0]   n_eff;
	logic                         src_snp;
	sgct_pkg::base_set_t          src_set;
	logic [NUM_ACCESSIONS-1:0]    active;
	logic [NUM_ACCESSIONS-1:0]    has_snp;
	logic [NUM_ACCESSIONS-1:0]    hit;
	logic [NUM_ACCESSIONS-1:0]    shared;

	// per-accession decode
	always_comb begin
		n_eff = (acc_in_use > sgct_pkg::CFG_W'(NUM_ACCESSIONS))
			? sgct_pkg::CFG_W'(NUM_ACCESSIONS) : acc_in_use;
		src_snp = (src_base != sgct_pkg::NO_SNP);
		src_set = sgct_pkg::expand_code(src_base);
		for (int i = 0; i < NUM_ACCESSIONS; i++) begin
			active[i]  = (sgct_pkg::CFG_W'(i) < n_eff);
			has_snp[i] = (acc_base[i] != sgct_pkg::NO_SNP);
			hit[i]     = |(sgct_pkg::char_bit(acc_base[i]) & src_set);
			shared[i]  = has_snp[i] && hit[i];
		end
	end

	// class codes, counter increments and global flags
	always_comb begin
		res.codes = '0;
		acc_inc   = '0;
		for (int i = 0; i < NUM_ACCESSIONS; i++) begin
			if (active[i]) begin
				if (!src_snp) begin
					if (has_snp[i]) begin
						res.codes[sgct_pkg::CODE_W*i +: sgct_pkg::CODE_W] = sgct_pkg::CLS_EXTRA;
						acc_inc[sgct_pkg::KINDS*i + sgct_pkg::KIND_EXTRA] = 1'b1;
					end
				end else if (!has_snp[i]) begin
					res.codes[sgct_pkg::CODE_W*i +: sgct_pkg::CODE_W] = sgct_pkg::CLS_ABSENT;
					acc_inc[sgct_pkg::KINDS*i + sgct_pkg::KIND_ABSENT] = 1'b1;
				end else if (hit[i]) begin
					res.codes[sgct_pkg::CODE_W*i +: sgct_pkg::CODE_W] = sgct_pkg::CLS_SHARED;
					acc_inc[sgct_pkg::KINDS*i + sgct_pkg::KIND_SHARED] = 1'b1;
				end else begin
					res.codes[sgct_pkg::CODE_W*i +: sgct_pkg::CODE_W] = sgct_pkg::CLS_DIFFER;
					acc_inc[sgct_pkg::KINDS*i + sgct_pkg::KIND_DIFFER] = 1'b1;
				end
			end
		end

		// "every accession" holds vacuously with none active
		res.flags = '0;
		res.flags[sgct_pkg::FLG_NOSRC_ALL]  = !src_snp && (&(has_snp | ~active));
		res.flags[sgct_pkg::FLG_EXTRA_ANY]  = !src_snp && (|(has_snp & active));
		res.flags[sgct_pkg::FLG_ABSENT_ALL] = src_snp && (&(~has_snp | ~active));
		res.flags[sgct_pkg::FLG_SHARED_ALL] = src_snp && (&(shared | ~active));
		res.flags[sgct_pkg::FLG_SHARED_ANY] = src_snp && (|(shared & active));
		res.flags[sgct_pkg::FLG_SRC_SNP]    = src_snp;
	end

endmodule
